// ----- rtl/core/psag_pkg.sv -----
package psag_pkg;

    localparam int EXT_W          = 11;
    localparam int EXT_FIELD_MAX  = (1 << EXT_W) - 1;
    localparam int VAL_W          = EXT_W + 2;
    localparam int MAG_W          = VAL_W - 1;
    localparam int STEP_W         = $clog2(MAG_W);
    localparam int DIM_CNT        = 3;
    localparam int DIMS_W         = 2;
    localparam int EB_W           = 5;
    localparam int IDX_W          = 30;
    localparam int BYTE_W         = 34;
    localparam int ROW_W          = 2 * EXT_W + 1;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = EXT_W;
    localparam int Q_DEPTH        = 2;
    localparam int MAX_EXTENT_DEF = 1024;
    localparam int MAX_DIMS_DEF   = 3;

    localparam int DIM_X = 0;
    localparam int DIM_Y = 1;
    localparam int DIM_Z = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMS,
        REG_GRID_X,
        REG_GRID_Y,
        REG_GRID_Z,
        REG_SUB_X,
        REG_SUB_Y,
        REG_SUB_Z,
        REG_EBYTES
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_ERR,
        KIND_ADDR
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_IDX,
        ST_BYTE,
        ST_OUT
    } t_back_st;

    // effective configuration: extents clamped, unused dimensions forced to 1
    typedef struct packed {
        logic [DIMS_W-1:0]               dims;
        logic [DIM_CNT-1:0][EXT_W-1:0]   grid;
        logic [DIM_CNT-1:0][EXT_W-1:0]   sub;
        logic [EB_W-1:0]                 ebytes;
    } t_cfg;

    // one classified item from front to back
    typedef struct packed {
        t_kind                    kind;
        logic                     dir;
        logic                     last;
        logic signed [VAL_W-1:0]  val_x;
        logic signed [VAL_W-1:0]  val_y;
        logic signed [VAL_W-1:0]  val_z;
    } t_cmd;

endpackage

// ----- rtl/core/psag_front.sv -----
module psag_front #(
    parameter int MAX_EXTENT = psag_pkg::MAX_EXTENT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  psag_pkg::t_cfg                       i_cfg,
    input  logic                                 i_in_valid,
    input  logic                                 i_q_full,
    input  logic                                 i_start_req,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_x,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_y,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_z,
    input  logic                                 i_into_grid,
    output logic                                 o_push,
    output psag_pkg::t_cmd                       o_cmd
);
    import psag_pkg::*;

    localparam int EXT_CAP = (MAX_EXTENT < EXT_FIELD_MAX) ? MAX_EXTENT : EXT_FIELD_MAX;
    localparam int CNT_W   = (EXT_CAP > 1) ? $clog2(EXT_CAP) : 1;

    logic [CNT_W-1:0]        r_cnt_x, r_cnt_y, r_cnt_z;
    logic [CNT_W-1:0]        n_cnt_x, n_cnt_y, n_cnt_z;
    logic signed [EXT_W-1:0] r_base_x, r_base_y, r_base_z;
    logic signed [EXT_W-1:0] n_base_x, n_base_y, n_base_z;
    logic                    r_active, n_active;
    logic                    r_dir, n_dir;

    logic signed [VAL_W-1:0] org_x, org_y, org_z;
    logic [CNT_W-1:0]        cur_x, cur_y, cur_z;
    logic                    bad, walk, cx, cy, cz;

    function automatic logic out_of_range(input logic signed [VAL_W-1:0] o,
                                          input logic [EXT_W-1:0] g);
        logic signed [VAL_W-1:0] gs;
        gs = $signed(VAL_W'(g));
        return (o < -gs) || (o >= gs);
    endfunction

    assign o_push = i_in_valid && !i_q_full;

    always_comb begin
        org_x = VAL_W'(i_origin_x);
        org_y = (i_cfg.dims > DIMS_W'(1)) ? VAL_W'(i_origin_y) : '0;
        org_z = (i_cfg.dims > DIMS_W'(2)) ? VAL_W'(i_origin_z) : '0;
        bad = i_start_req && (out_of_range(org_x, i_cfg.grid[DIM_X])
                           || out_of_range(org_y, i_cfg.grid[DIM_Y])
                           || out_of_range(org_z, i_cfg.grid[DIM_Z]));

        n_base_x = r_base_x;
        n_base_y = r_base_y;
        n_base_z = r_base_z;
        n_dir    = r_dir;
        cur_x    = r_cnt_x;
        cur_y    = r_cnt_y;
        cur_z    = r_cnt_z;
        if (i_start_req && !bad) begin
            n_base_x = EXT_W'(org_x);
            n_base_y = EXT_W'(org_y);
            n_base_z = EXT_W'(org_z);
            n_dir    = i_into_grid;
            cur_x    = '0;
            cur_y    = '0;
            cur_z    = '0;
        end
        walk = i_start_req ? !bad : r_active;

        cx = ((EXT_W+1)'(cur_x) + (EXT_W+1)'(1)) >= {1'b0, i_cfg.sub[DIM_X]};
        cy = (i_cfg.dims < DIMS_W'(2))
          || (((EXT_W+1)'(cur_y) + (EXT_W+1)'(1)) >= {1'b0, i_cfg.sub[DIM_Y]});
        cz = (i_cfg.dims < DIMS_W'(3))
          || (((EXT_W+1)'(cur_z) + (EXT_W+1)'(1)) >= {1'b0, i_cfg.sub[DIM_Z]});

        n_cnt_x  = cur_x;
        n_cnt_y  = cur_y;
        n_cnt_z  = cur_z;
        n_active = walk;
        o_cmd      = '0;
        o_cmd.kind = bad ? KIND_ERR : KIND_IDLE;
        if (walk) begin
            o_cmd.kind  = KIND_ADDR;
            o_cmd.dir   = n_dir;
            o_cmd.last  = cx && cy && cz;
            o_cmd.val_x = VAL_W'(n_base_x) + VAL_W'({1'b0, cur_x});
            o_cmd.val_y = (i_cfg.dims > DIMS_W'(1))
                        ? VAL_W'(n_base_y) + VAL_W'({1'b0, cur_y}) : '0;
            o_cmd.val_z = (i_cfg.dims > DIMS_W'(2))
                        ? VAL_W'(n_base_z) + VAL_W'({1'b0, cur_z}) : '0;
            if (cx) begin
                n_cnt_x = '0;
                if (cy) begin
                    n_cnt_y = '0;
                    if (cz) begin
                        n_cnt_z  = '0;
                        n_active = 1'b0;
                    end else begin
                        n_cnt_z = cur_z + CNT_W'(1);
                    end
                end else begin
                    n_cnt_y = cur_y + CNT_W'(1);
                end
            end else begin
                n_cnt_x = cur_x + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_x  <= '0;
            r_cnt_y  <= '0;
            r_cnt_z  <= '0;
            r_base_x <= '0;
            r_base_y <= '0;
            r_base_z <= '0;
            r_active <= 1'b0;
            r_dir    <= 1'b0;
        end else if (o_push) begin
            r_cnt_x  <= n_cnt_x;
            r_cnt_y  <= n_cnt_y;
            r_cnt_z  <= n_cnt_z;
            r_base_x <= n_base_x;
            r_base_y <= n_base_y;
            r_base_z <= n_base_z;
            r_active <= n_active;
            r_dir    <= n_dir;
        end
    end

endmodule

// ----- rtl/core/psag_fifo.sv -----
module psag_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psag_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output psag_pkg::t_cmd  o_cmd
);
    import psag_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/psag_mod.sv -----
module psag_mod (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [psag_pkg::VAL_W-1:0]  i_value,
    input  logic [psag_pkg::EXT_W-1:0]         i_len,
    output logic                               o_done,
    output logic [psag_pkg::EXT_W-1:0]         o_coord
);
    import psag_pkg::*;

    logic              r_busy, r_done, r_neg;
    logic [STEP_W-1:0] r_cnt;
    logic [MAG_W-1:0]  r_mag;
    logic [EXT_W-1:0]  r_rem;

    logic [EXT_W:0]    trial;
    logic [EXT_W-1:0]  n_rem;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial = {r_rem, r_mag[MAG_W-1]};
        if (trial >= {1'b0, i_len}) begin
            n_rem = EXT_W'(trial - {1'b0, i_len});
        end else begin
            n_rem = EXT_W'(trial);
        end
    end

    assign o_done  = r_done;
    assign o_coord = (r_neg && (r_rem != '0)) ? i_len - r_rem : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(MAG_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_value < 0;
            r_mag <= MAG_W'((i_value < 0) ? -i_value : i_value);
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= r_mag << 1;
            r_rem <= n_rem;
        end
    end

endmodule

// ----- rtl/core/psag_back.sv -----
module psag_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psag_pkg::t_cfg                i_cfg,
    input  logic                          i_empty,
    input  psag_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic                          o_valid_res,
    output logic [psag_pkg::IDX_W-1:0]    o_element_index,
    output logic [psag_pkg::BYTE_W-1:0]   o_byte_offset,
    output logic                          o_write_to_grid,
    output logic                          o_last,
    output logic                          o_offset_error
);
    import psag_pkg::*;

    localparam int SUM_W  = ROW_W + EXT_W;
    localparam int PROD_W = IDX_W + EB_W;

    t_back_st r_st, n_st;
    t_cmd     r_cmd;

    logic                   mod_start, out_free, out_load, all_done;
    logic                   done_x, done_y, done_z;
    logic [EXT_W-1:0]       crd_x, crd_y, crd_z;
    logic [ROW_W-1:0]       row_sum;
    logic [SUM_W-1:0]       idx_sum;
    logic [PROD_W-1:0]      byte_prod;
    logic [ROW_W-1:0]       r_row;
    logic [IDX_W-1:0]       r_idx;
    logic [BYTE_W-1:0]      r_byte;
    logic                   r_out_valid;

    psag_mod u_mod_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_cmd.val_x),
        .i_len   (i_cfg.grid[DIM_X]),
        .o_done  (done_x),
        .o_coord (crd_x)
    );

    psag_mod u_mod_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_cmd.val_y),
        .i_len   (i_cfg.grid[DIM_Y]),
        .o_done  (done_y),
        .o_coord (crd_y)
    );

    psag_mod u_mod_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_cmd.val_z),
        .i_len   (i_cfg.grid[DIM_Z]),
        .o_done  (done_z),
        .o_coord (crd_z)
    );

    assign all_done  = done_x && done_y && done_z;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign row_sum   = ROW_W'(i_cfg.grid[DIM_Y]) * ROW_W'(crd_z) + ROW_W'(crd_y);
    assign idx_sum   = SUM_W'(i_cfg.grid[DIM_X]) * SUM_W'(r_row) + SUM_W'(crd_x);
    assign byte_prod = PROD_W'(r_idx) * PROD_W'(i_cfg.ebytes);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_st = (i_cmd.kind == KIND_ADDR) ? ST_WRAP : ST_OUT;
                end
            end
            ST_WRAP: begin
                if (all_done) begin
                    n_st = ST_IDX;
                end
            end
            ST_IDX:  n_st = ST_BYTE;
            ST_BYTE: n_st = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_st == ST_IDLE) && !i_empty;
        mod_start = o_pop && (i_cmd.kind == KIND_ADDR);
        out_load  = (r_st == ST_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if ((r_st == ST_WRAP) && all_done) begin
            r_row <= row_sum;
        end
        if (r_st == ST_IDX) begin
            r_idx <= idx_sum[IDX_W-1:0];
        end
        if (r_st == ST_BYTE) begin
            r_byte <= byte_prod[BYTE_W-1:0];
        end
        if (out_load) begin
            case (r_cmd.kind)
                KIND_ADDR: begin
                    o_valid_res     <= 1'b1;
                    o_element_index <= r_idx;
                    o_byte_offset   <= r_byte;
                    o_write_to_grid <= r_cmd.dir;
                    o_last          <= r_cmd.last;
                    o_offset_error  <= 1'b0;
                end
                KIND_ERR: begin
                    o_valid_res     <= 1'b0;
                    o_element_index <= '0;
                    o_byte_offset   <= '0;
                    o_write_to_grid <= 1'b0;
                    o_last          <= 1'b0;
                    o_offset_error  <= 1'b1;
                end
                default: begin
                    o_valid_res     <= 1'b0;
                    o_element_index <= '0;
                    o_byte_offset   <= '0;
                    o_write_to_grid <= 1'b0;
                    o_last          <= 1'b0;
                    o_offset_error  <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/periodic_subgrid_address_generator.sv -----
// An address item goes from acceptance through a remainder per coordinate, then
// the row, index and byte multiply stages; a rejected start or an idle request
// goes from the queue straight to the output stage.
// The back end holds one item at a time and pops the next after loading a result;
// the two-entry queue absorbs items while the back end works.
// Reset: synchronous active low; clears the walk, queue, sequencer and registers.
module periodic_subgrid_address_generator #(
    parameter int MAX_EXTENT = psag_pkg::MAX_EXTENT_DEF,
    parameter int MAX_DIMS   = psag_pkg::MAX_DIMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psag_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psag_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_start_req,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_x,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_y,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_z,
    input  logic                                 i_into_grid,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_valid_res,
    output logic [psag_pkg::IDX_W-1:0]           o_element_index,
    output logic [psag_pkg::BYTE_W-1:0]          o_byte_offset,
    output logic                                 o_write_to_grid,
    output logic                                 o_last,
    output logic                                 o_offset_error
);
    import psag_pkg::*;

    localparam int EXT_CAP = (MAX_EXTENT < EXT_FIELD_MAX) ? MAX_EXTENT : EXT_FIELD_MAX;

    logic [DIMS_W-1:0] r_dims;
    logic [EXT_W-1:0]  r_grid [DIM_CNT];
    logic [EXT_W-1:0]  r_sub  [DIM_CNT];
    logic [EB_W-1:0]   r_eb;

    logic [DIMS_W-1:0] dims_eff;
    t_cfg              cfg;
    logic              push, pop, q_full, q_empty;
    t_cmd              f_cmd, q_cmd;

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
        if (v == '0) begin
            return EXT_W'(1);
        end else if (v > EXT_W'(EXT_CAP)) begin
            return EXT_W'(EXT_CAP);
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(3);
            for (int k = 0; k < DIM_CNT; k++) begin
                r_grid[k] <= EXT_W'(1);
                r_sub[k]  <= EXT_W'(1);
            end
            r_eb <= EB_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_DIMS:   r_dims        <= i_cfg_data[DIMS_W-1:0];
                REG_GRID_X: r_grid[DIM_X] <= i_cfg_data[EXT_W-1:0];
                REG_GRID_Y: r_grid[DIM_Y] <= i_cfg_data[EXT_W-1:0];
                REG_GRID_Z: r_grid[DIM_Z] <= i_cfg_data[EXT_W-1:0];
                REG_SUB_X:  r_sub[DIM_X]  <= i_cfg_data[EXT_W-1:0];
                REG_SUB_Y:  r_sub[DIM_Y]  <= i_cfg_data[EXT_W-1:0];
                REG_SUB_Z:  r_sub[DIM_Z]  <= i_cfg_data[EXT_W-1:0];
                REG_EBYTES: r_eb          <= i_cfg_data[EB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        dims_eff = r_dims;
        if (r_dims == '0) begin
            dims_eff = DIMS_W'(1);
        end else if (r_dims > DIMS_W'(MAX_DIMS)) begin
            dims_eff = DIMS_W'(MAX_DIMS);
        end
    end

    always_comb begin
        cfg.dims   = dims_eff;
        cfg.ebytes = r_eb;
        for (int k = 0; k < DIM_CNT; k++) begin
            cfg.grid[k] = (dims_eff > DIMS_W'(k)) ? clamp_ext(r_grid[k]) : EXT_W'(1);
            cfg.sub[k]  = (dims_eff > DIMS_W'(k)) ? clamp_ext(r_sub[k])  : EXT_W'(1);
        end
    end

    assign o_in_stall = q_full;

    psag_front #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_q_full    (q_full),
        .i_start_req (i_start_req),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_origin_z  (i_origin_z),
        .i_into_grid (i_into_grid),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    psag_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    psag_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_empty         (q_empty),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_valid_res     (o_valid_res),
        .o_element_index (o_element_index),
        .o_byte_offset   (o_byte_offset),
        .o_write_to_grid (o_write_to_grid),
        .o_last          (o_last),
        .o_offset_error  (o_offset_error)
    );

endmodule

// ----- tb/addr_walk_checker.sv -----
`timescale 1ns / 1ps
module addr_walk_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [psag_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psag_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic                                 i_start_req,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_x,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_y,
    input  logic signed [psag_pkg::EXT_W-1:0]    i_origin_z,
    input  logic                                 i_into_grid,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_valid_res,
    input  logic [psag_pkg::IDX_W-1:0]           i_element_index,
    input  logic [psag_pkg::BYTE_W-1:0]          i_byte_offset,
    input  logic                                 i_write_to_grid,
    input  logic                                 i_last,
    input  logic                                 i_offset_error,
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_addr_count,
    output int                                   o_walk_count,
    output int                                   o_reject_count
);
    import psag_pkg::*;

    typedef struct packed {
        logic               valid_res;
        logic [IDX_W-1:0]   element_index;
        logic [BYTE_W-1:0]  byte_offset;
        logic               write_to_grid;
        logic               last;
        logic               offset_error;
    } t_addr_rec;

    t_addr_rec pending_addrs[$];

    logic [DIMS_W-1:0] dims_reg;
    logic [EXT_W-1:0]  grid_reg [DIM_CNT];
    logic [EXT_W-1:0]  sub_reg [DIM_CNT];
    logic [EB_W-1:0]   ebytes_reg;

    int cnt [DIM_CNT];
    int base [DIM_CNT];
    bit walking;
    bit dir_q;

    function automatic int clamp_extent(logic [EXT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_EXTENT_DEF) return MAX_EXTENT_DEF;
        return int'(v);
    endfunction

    function automatic int fold(int v, int g);
        int m;
        m = v % g;
        if (m < 0) m += g;
        return m;
    endfunction

    // one request step: handles a start, updates the counters and returns the record it yields
    function automatic t_addr_rec next_address(bit start, int ox, int oy, int oz, bit into);
        t_addr_rec rec;
        int dims;
        int g [DIM_CNT];
        int s [DIM_CNT];
        int org [DIM_CNT];
        int crd [DIM_CNT];
        bit bad;
        logic [2:0] wrap;
        longint idx;
        rec = '0;
        dims = (dims_reg == 0) ? 1 : int'(dims_reg);
        for (int k = 0; k < DIM_CNT; k++) begin
            g[k] = (k < dims) ? clamp_extent(grid_reg[k]) : 1;
            s[k] = (k < dims) ? clamp_extent(sub_reg[k]) : 1;
        end
        if (start) begin
            org[DIM_X] = ox;
            org[DIM_Y] = oy;
            org[DIM_Z] = oz;
            bad = 1'b0;
            for (int k = 0; k < DIM_CNT; k++) begin
                if (k >= dims) begin
                    org[k] = 0;
                end else if (org[k] < -g[k] || org[k] >= g[k]) begin
                    bad = 1'b1;
                end
            end
            if (bad) begin
                walking = 1'b0;
                rec.offset_error = 1'b1;
                return rec;
            end
            base = org;
            dir_q = into;
            cnt = '{0, 0, 0};
            walking = 1'b1;
        end
        if (!walking) return rec;
        for (int k = 0; k < DIM_CNT; k++) begin
            crd[k] = (k < dims) ? fold(base[k] + cnt[k], g[k]) : 0;
            wrap[k] = (k >= dims) || (cnt[k] + 1 >= s[k]);
        end
        idx = longint'(crd[DIM_X])
            + longint'(g[DIM_X]) * (longint'(crd[DIM_Y])
            + longint'(g[DIM_Y]) * longint'(crd[DIM_Z]));
        rec.valid_res = 1'b1;
        rec.element_index = idx[IDX_W-1:0];
        rec.byte_offset = BYTE_W'(longint'(rec.element_index) * longint'(ebytes_reg));
        rec.write_to_grid = dir_q;
        rec.last = &wrap;
        if (wrap[DIM_X]) begin
            cnt[DIM_X] = 0;
            if (wrap[DIM_Y]) begin
                cnt[DIM_Y] = 0;
                if (wrap[DIM_Z]) begin
                    cnt[DIM_Z] = 0;
                    walking = 1'b0;
                end else begin
                    cnt[DIM_Z]++;
                end
            end else begin
                cnt[DIM_Y]++;
            end
        end else begin
            cnt[DIM_X]++;
        end
        return rec;
    endfunction

    function automatic int diff_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_addr_rec want;
        t_addr_rec fresh;
        if (!i_rst_n) begin
            pending_addrs.delete();
            dims_reg = 2'd3;
            grid_reg = '{default: 11'd1};
            sub_reg = '{default: 11'd1};
            ebytes_reg = 5'd4;
            cnt = '{0, 0, 0};
            base = '{0, 0, 0};
            walking = 1'b0;
            dir_q = 1'b0;
            o_mismatches = 0;
            o_addr_count = 0;
            o_walk_count = 0;
            o_reject_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_DIMS:   dims_reg = i_cfg_data[DIMS_W-1:0];
                    REG_GRID_X: grid_reg[DIM_X] = i_cfg_data;
                    REG_GRID_Y: grid_reg[DIM_Y] = i_cfg_data;
                    REG_GRID_Z: grid_reg[DIM_Z] = i_cfg_data;
                    REG_SUB_X:  sub_reg[DIM_X] = i_cfg_data;
                    REG_SUB_Y:  sub_reg[DIM_Y] = i_cfg_data;
                    REG_SUB_Z:  sub_reg[DIM_Z] = i_cfg_data;
                    REG_EBYTES: ebytes_reg = i_cfg_data[EB_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_addrs.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    o_mismatches++;
                end else begin
                    want = pending_addrs.pop_front();
                    o_mismatches += diff_field("valid_res", want.valid_res, i_valid_res)
                        + diff_field("element_index", want.element_index, i_element_index)
                        + diff_field("byte_offset", want.byte_offset, i_byte_offset)
                        + diff_field("write_to_grid", want.write_to_grid, i_write_to_grid)
                        + diff_field("last", want.last, i_last)
                        + diff_field("offset_error", want.offset_error, i_offset_error);
                    o_addr_count += want.valid_res;
                    o_walk_count += want.last;
                    o_reject_count += want.offset_error;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = next_address(i_start_req, int'(i_origin_x),
                    int'(i_origin_y), int'(i_origin_z), i_into_grid);
                pending_addrs.insert(pending_addrs.size(), fresh);
            end
        end
        o_outstanding = pending_addrs.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import psag_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    req_valid;
    logic                    req_stall;
    logic                    req_start;
    logic signed [EXT_W-1:0] req_ox;
    logic signed [EXT_W-1:0] req_oy;
    logic signed [EXT_W-1:0] req_oz;
    logic                    req_into;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic                    res_valid_res;
    logic [IDX_W-1:0]        res_index;
    logic [BYTE_W-1:0]       res_bytes;
    logic                    res_to_grid;
    logic                    res_last;
    logic                    res_oerr;

    bit calm;
    int mismatches;
    int outstanding;
    int addr_count;
    int walk_count;
    int reject_count;
    int item_count;
    int phase_count;
    int cur_dims;
    int grid_eff [DIM_CNT];
    int sub_eff [DIM_CNT];

    periodic_subgrid_address_generator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (req_valid),
        .o_in_stall      (req_stall),
        .i_start_req     (req_start),
        .i_origin_x      (req_ox),
        .i_origin_y      (req_oy),
        .i_origin_z      (req_oz),
        .i_into_grid     (req_into),
        .o_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .o_valid_res     (res_valid_res),
        .o_element_index (res_index),
        .o_byte_offset   (res_bytes),
        .o_write_to_grid (res_to_grid),
        .o_last          (res_last),
        .o_offset_error  (res_oerr)
    );

    addr_walk_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (req_valid),
        .i_in_stall      (req_stall),
        .i_start_req     (req_start),
        .i_origin_x      (req_ox),
        .i_origin_y      (req_oy),
        .i_origin_z      (req_oz),
        .i_into_grid     (req_into),
        .i_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .i_valid_res     (res_valid_res),
        .i_element_index (res_index),
        .i_byte_offset   (res_bytes),
        .i_write_to_grid (res_to_grid),
        .i_last          (res_last),
        .i_offset_error  (res_oerr),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_addr_count    (addr_count),
        .o_walk_count    (walk_count),
        .o_reject_count  (reject_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk) begin
        res_stall <= !calm && ($urandom_range(99) < 29);
    end

    function automatic int clamp_len(int v);
        if (v == 0) return 1;
        if (v > MAX_EXTENT_DEF) return MAX_EXTENT_DEF;
        return v;
    endfunction

    function automatic int rand_origin();
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    function automatic int origin_in(int k);
        return int'($urandom_range(0, 2 * grid_eff[k] - 1)) - grid_eff[k];
    endfunction

    function automatic longint walk_len();
        longint n;
        n = 1;
        for (int k = 0; k < cur_dims; k++) n *= sub_eff[k];
        return n;
    endfunction

    task automatic put_reg(t_cfg_reg id, int value);
        cfg_index = id;
        cfg_data = CFG_DATA_W'(value);
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_config(int dims, int gx, int gy, int gz,
                                int sx, int sy, int sz, int eb);
        put_reg(REG_DIMS, dims);
        put_reg(REG_GRID_X, gx);
        put_reg(REG_GRID_Y, gy);
        put_reg(REG_GRID_Z, gz);
        put_reg(REG_SUB_X, sx);
        put_reg(REG_SUB_Y, sy);
        put_reg(REG_SUB_Z, sz);
        put_reg(REG_EBYTES, eb);
        cfg_valid = 1'b0;
        cur_dims = (dims % 4 == 0) ? 1 : dims % 4;
        grid_eff = '{clamp_len(gx % 2048), clamp_len(gy % 2048), clamp_len(gz % 2048)};
        sub_eff = '{clamp_len(sx % 2048), clamp_len(sy % 2048), clamp_len(sz % 2048)};
        phase_count++;
    endtask

    task automatic issue_request(bit start, int ox, int oy, int oz, bit into);
        while (!calm && $urandom_range(99) < 29) begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_start = start;
        req_ox = EXT_W'(ox);
        req_oy = EXT_W'(oy);
        req_oz = EXT_W'(oz);
        req_into = into;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
        req_valid = 1'b0;
        item_count++;
    endtask

    // non-start items; origin and direction bits are don't-care here
    task automatic advance(int n);
        for (int i = 0; i < n; i++) begin
            issue_request(1'b0, rand_origin(), rand_origin(), rand_origin(),
                1'($urandom_range(1)));
        end
    endtask

    task automatic drain();
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic random_config();
        int ext [6];
        int r;
        for (int k = 0; k < 6; k++) begin
            r = $urandom_range(99);
            if (k < 3) begin
                if (r < 8) ext[k] = 0;
                else if (r < 14) ext[k] = 1024;
                else if (r < 18) ext[k] = $urandom_range(1025, 2047);
                else if (r < 26) ext[k] = $urandom_range(1, 1023);
                else ext[k] = $urandom_range(1, 12);
            end else begin
                if (r < 5) ext[k] = 0;
                else if (r < 9) ext[k] = $urandom_range(13, 2047);
                else ext[k] = $urandom_range(1, 5);
            end
        end
        write_config($urandom_range(0, 3), ext[0], ext[1], ext[2],
            ext[3], ext[4], ext[5], $urandom_range(0, 31));
    endtask

    task automatic random_transfer();
        int r;
        int n;
        longint len;
        r = $urandom_range(99);
        if (r < 8) begin
            advance($urandom_range(1, 3));
        end else if (r < 18) begin
            issue_request(1'b1, rand_origin(), rand_origin(), rand_origin(),
                1'($urandom_range(1)));
            advance($urandom_range(0, 3));
        end else begin
            len = walk_len();
            n = (len > 30) ? $urandom_range(1, 30) : int'(len);
            if ($urandom_range(9) == 0) n = $urandom_range(1, n);
            issue_request(1'b1, origin_in(DIM_X), origin_in(DIM_Y), origin_in(DIM_Z),
                1'($urandom_range(1)));
            advance(n - 1 + $urandom_range(0, 1));
        end
    endtask

    initial begin
        int calm_phase;
        int target;
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        req_start = 1'b0;
        req_ox = '0;
        req_oy = '0;
        req_oz = '0;
        req_into = 1'b0;
        cur_dims = 3;
        grid_eff = '{1, 1, 1};
        sub_eff = '{1, 1, 1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: idle request, single-element walk, idle again
        advance(1);
        issue_request(1'b1, 0, 0, 0, 1'b1);
        advance(1);
        drain();

        // saturated grids, origin -1 gives the top index; restarts mid-walk
        write_config(3, 2047, 2047, 2047, 2, 2, 2, 16);
        issue_request(1'b1, -1, -1, -1, 1'b1);
        advance(8);
        issue_request(1'b1, -1024, 1023, -1024, 1'b0);
        advance(1);
        issue_request(1'b1, 1023, -1024, 1023, 1'b1);
        advance(1);
        drain();

        // dims 0 acts as 1; unused origins ignored; bad origins on both sides
        write_config(0, 5, 0, 9, 3, 0, 2047, 31);
        issue_request(1'b1, -5, 1023, -1024, 1'b1);
        advance(2);
        issue_request(1'b1, 5, 0, 0, 1'b0);
        advance(1);
        issue_request(1'b1, -6, 0, 0, 1'b1);
        issue_request(1'b1, 4, -1024, 1023, 1'b0);
        advance(1);
        drain();

        calm_phase = $urandom_range(1, 3);
        for (int phase = 0; item_count < 550; phase++) begin
            calm = (phase == calm_phase);
            random_config();
            target = item_count + $urandom_range(50, 80);
            if (target > 550) target = 550;
            while (item_count < target) random_transfer();
            drain();
        end
        calm = 1'b0;
        req_valid = 1'b0;
        drain();
        repeat (20) @(negedge clk);

        $display("%0d items across %0d register settings: %0d addresses, %0d full walks,",
            item_count, phase_count, addr_count, walk_count);
        $display("%0d rejected starts, remainder idle replies.", reject_count);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
